// ===== rtl/core/lock_gain_step_calculator_top_macros.svh =====
// Assertion macros for the lock gain step calculator.
// Used by rtl/core/lock_gain_step_calculator_top.sv; needs clk and rst_n in scope.
`ifndef LOCK_GAIN_STEP_CALCULATOR_TOP_MACROS_SVH
`define LOCK_GAIN_STEP_CALCULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LGSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgsc assertion failed");

// Next-cycle implication, checked out of reset.
`define LGSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgsc assertion failed");

`endif

// ===== rtl/core/lgsc_pkg.sv =====
// Shared constants of the lock gain step calculator.
// No dependencies.
`default_nettype none
package lgsc_pkg;
    localparam int          LEVEL_BITS_DEF = 20;
    localparam logic [31:0] TARGET_RESET   = 32'd1000;
    localparam int          STEP_DB        = 6;
    localparam int          FINE_MAX       = 6;
    localparam int          GAIN_MAX       = 127;
endpackage
`default_nettype wire

// ===== rtl/core/lock_gain_step_calculator_top.sv =====
// Lock gain step calculator: five-stage pipeline from level to gain step.
// Depends on lgsc_pkg and lock_gain_step_calculator_top_macros.svh.
//
//  channel   valid / ready          payload
//  input     in_valid / in_ready    measured_level
//  config    cfg_valid / cfg_ready  target_level
//  output    out_valid / out_ready  gain_change_db, level_error
//
// One request may enter every cycle while no held output stalls the pipeline.
// All stages advance together; a held output stalls the whole pipeline.
// rst_n clears the valid bits and loads the target with 1000.
// The target is sampled with each request in the first stage.
`default_nettype none
`include "lock_gain_step_calculator_top_macros.svh"
module lock_gain_step_calculator_top
    import lgsc_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [LEVEL_BITS-1:0] measured_level,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [LEVEL_BITS-1:0] target_level,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [7:0]          gain_change_db,
    output logic                       level_error
);
    localparam int LB = LEVEL_BITS;
    localparam int KW = $clog2(LB + 1);
    localparam int DW = LB + 6;   // deadband products
    localparam int FW = LB + 9;   // fine products

    logic [LB-1:0] tgt_reg;
    logic          adv;

    logic          s1_v_reg;
    logic [LB-1:0] s1_lvl_reg, s1_tgt_reg;

    logic          s2_v_reg, s2_err_reg, s2_zero_reg, s2_hi_reg;
    logic [KW-1:0] s2_k_reg;
    logic [LB-1:0] s2_lvl_reg, s2_tgt_reg;

    logic          s3_v_reg, s3_err_reg, s3_zero_reg, s3_hi_reg;
    logic [KW-1:0] s3_k_reg;
    logic [LB:0]   s3_lp_reg, s3_rem_reg;

    logic          s4_v_reg, s4_err_reg, s4_zero_reg, s4_hi_reg;
    logic [KW-1:0] s4_k_reg;
    logic [2:0]    s4_fine_reg;

    logic          out_v_reg, out_err_reg;
    logic [7:0]    out_gain_reg;

    assign adv       = !out_v_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign out_valid = out_v_reg;
    assign gain_change_db = out_gain_reg;
    assign level_error    = out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg <= TARGET_RESET[LB-1:0];
        end
        else if (cfg_valid)
        begin
            tgt_reg <= target_level;
        end
    end

    // stage 2 logic: error, deadband, shift count
    logic          c2_err, c2_dead, c2_hi;
    logic [LB-1:0] c2_diff;
    logic [KW-1:0] c2_k;
    logic [2*LB-1:0] c2_wide_lvl, c2_wide_tgt;
    always_comb
    begin
        c2_err  = (s1_lvl_reg == '0) || (s1_tgt_reg == '0);
        c2_hi   = s1_lvl_reg > s1_tgt_reg;
        c2_diff = c2_hi ? (s1_lvl_reg - s1_tgt_reg) : (s1_tgt_reg - s1_lvl_reg);
        c2_dead = (DW'(c2_diff) * DW'(25)) < (DW'(s1_tgt_reg) * DW'(4));
        c2_wide_lvl = (2*LB)'(s1_lvl_reg);
        c2_wide_tgt = (2*LB)'(s1_tgt_reg);
        c2_k = '0;
        for (int i = LB; i >= 0; i--)
        begin
            if (c2_hi)
            begin
                if ((s1_lvl_reg >> i) <= s1_tgt_reg)
                    c2_k = KW'(i);
            end
            else
            begin
                if ((c2_wide_lvl << i) >= c2_wide_tgt)
                    c2_k = KW'(i);
            end
        end
    end

    // stage 3 logic: shifted level and remainder
    logic [2*LB-1:0] c3_wide;
    logic [LB:0]     c3_lp, c3_tgt, c3_rem;
    always_comb
    begin
        c3_wide = s2_hi_reg ? ((2*LB)'(s2_lvl_reg) >> s2_k_reg)
                            : ((2*LB)'(s2_lvl_reg) << s2_k_reg);
        c3_lp  = c3_wide[LB:0];
        c3_tgt = (LB+1)'(s2_tgt_reg);
        c3_rem = (c3_lp > c3_tgt) ? (c3_lp - c3_tgt) : (c3_tgt - c3_lp);
    end

    // stage 4 logic: fine step f counts when rem*125 >= lp*(20f-10)
    logic [2:0]    c4_fine;
    logic [FW-1:0] c4_lhs;
    always_comb
    begin
        c4_lhs  = FW'(s3_rem_reg) * FW'(125);
        c4_fine = '0;
        for (int f = 1; f <= FINE_MAX; f++)
        begin
            if (c4_lhs >= FW'(s3_lp_reg) * FW'(20 * f - 10))
                c4_fine = c4_fine + 3'd1;
        end
    end

    // stage 5 logic: combine and saturate
    logic [9:0]        c5_coarse;
    logic signed [9:0] c5_total;
    logic [7:0]        c5_gain;
    always_comb
    begin
        c5_coarse = 10'(s4_k_reg) * 10'(STEP_DB);
        c5_total  = s4_hi_reg ? $signed(10'(s4_fine_reg) - c5_coarse)
                              : $signed(c5_coarse - 10'(s4_fine_reg));
        if (s4_zero_reg)
            c5_gain = '0;
        else if (c5_total > 10'sd127)
            c5_gain = 8'(GAIN_MAX);
        else if (c5_total < -10'sd127)
            c5_gain = 8'(-GAIN_MAX);
        else
            c5_gain = c5_total[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= in_valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            out_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_lvl_reg  <= measured_level;
            s1_tgt_reg  <= tgt_reg;

            s2_err_reg  <= c2_err;
            s2_zero_reg <= c2_err || c2_dead;
            s2_hi_reg   <= c2_hi;
            s2_k_reg    <= c2_k;
            s2_lvl_reg  <= s1_lvl_reg;
            s2_tgt_reg  <= s1_tgt_reg;

            s3_err_reg  <= s2_err_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_hi_reg   <= s2_hi_reg;
            s3_k_reg    <= s2_k_reg;
            s3_lp_reg   <= c3_lp;
            s3_rem_reg  <= c3_rem;

            s4_err_reg  <= s3_err_reg;
            s4_zero_reg <= s3_zero_reg;
            s4_hi_reg   <= s3_hi_reg;
            s4_k_reg    <= s3_k_reg;
            s4_fine_reg <= c4_fine;

            out_err_reg  <= s4_err_reg;
            out_gain_reg <= c5_gain;
        end
    end

    `LGSC_ASSERT_NOW(a_err_gives_zero, out_v_reg && out_err_reg, out_gain_reg == 8'd0)
    `LGSC_ASSERT_NOW(a_gain_in_range, out_v_reg, out_gain_reg != 8'h80)
    `LGSC_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, s1_v_reg)
    `LGSC_ASSERT_NEXT(a_stall_holds_s4, !adv, s4_v_reg == $past(s4_v_reg))
endmodule
`default_nettype wire

// ===== tb/tb_lock_gain_step_calculator_top.sv =====
// Testbench for the lock gain step calculator: random and directed level requests
// checked against a behavioral gain predictor. Depends on lgsc_pkg and the top RTL.
`timescale 1ns / 1ps

class gain_scoreboard;
    logic [19:0]       target;
    logic signed [7:0] gain_q[$];
    logic              err_q[$];
    int                errors;

    function new();
        target = 20'd1000;
        errors = 0;
    endfunction

    function logic signed [7:0] gain_of(logic [19:0] lvl, logic [19:0] tgt);
        longint unsigned l, t, diff, rel, rem, pct;
        longint steps, dir, fine, total;
        l = lvl;
        t = tgt;
        steps = 0;
        dir = 0;
        diff = (l > t) ? l - t : t - l;
        rel = (diff * 1000) / t;
        if (rel < 160)
            return 8'sd0;
        if (l > t)
        begin
            while (l > t)
            begin
                l = l >> 1;
                steps--;
            end
            dir = 1;
        end
        else
        begin
            while (l < t)
            begin
                l = l << 1;
                steps++;
            end
            dir = -1;
        end
        rem = (l > t) ? l - t : t - l;
        pct = (rem * 1000) / l;
        fine = longint'(((pct / 16) + 5) / 10) * dir;
        total = 6 * steps + fine;
        if (total > 127) total = 127;
        if (total < -127) total = -127;
        return total[7:0];
    endfunction

    function void note_level(logic [19:0] lvl);
        if (lvl == 0 || target == 0)
        begin
            gain_q.push_back(8'sd0);
            err_q.push_back(1'b1);
        end
        else
        begin
            gain_q.push_back(gain_of(lvl, target));
            err_q.push_back(1'b0);
        end
    endfunction

    function void check_gain(logic signed [7:0] gain, logic err);
        logic signed [7:0] eg;
        logic              ee;
        if (gain_q.size() == 0)
        begin
            $display("%0t: unexpected result gain %0d err %0b", $time, gain, err);
            errors++;
            return;
        end
        eg = gain_q.pop_front();
        ee = err_q.pop_front();
        if (gain !== eg)
        begin
            $display("%0t: gain mismatch expected %0d actual %0d", $time, eg, gain);
            errors++;
        end
        if (err !== ee)
        begin
            $display("%0t: level_error mismatch expected %0b actual %0b", $time, ee, err);
            errors++;
        end
    endfunction
endclass

module tb_lock_gain_step_calculator_top;
    import lgsc_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [19:0]       measured_level;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [19:0]       target_level;
    logic              out_valid;
    logic              out_ready;
    logic signed [7:0] gain_change_db;
    logic              level_error;
    logic              sink_on;
    int                sink_wait;
    int                sink_draw;

    gain_scoreboard sb;

    lock_gain_step_calculator_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .measured_level (measured_level),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .target_level   (target_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .gain_change_db (gain_change_db),
        .level_error    (level_error)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // valid stays up after the accept; the next request or drain() takes it over
    task automatic send_level(logic [19:0] lvl, bit gaps);
        int n;
        n = 0;
        if (gaps) n = $urandom_range(0, 5);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            idle_cycles(n);
        end
        in_valid <= 1'b1;
        measured_level <= lvl;
        do @(posedge clk); while (!in_ready);
        sb.note_level(lvl);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.gain_q.size() != 0) @(posedge clk);
        idle_cycles(10);
    endtask

    task automatic write_target(logic [19:0] tgt);
        drain();
        cfg_valid <= 1'b1;
        target_level <= tgt;
        do @(posedge clk); while (!cfg_ready);
        sb.target = tgt;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [19:0] rand_level(logic [19:0] tgt);
        int unsigned pick;
        longint unsigned v;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 20'($urandom());
            1: return 20'd0;
            2: return 20'hFFFFF;
            3, 4:
            begin
                // near the dead band edge
                v = tgt + ((longint'(tgt) * $urandom_range(0, 400)) / 1000);
                if ($urandom_range(0, 1)) v = tgt - ((longint'(tgt) * $urandom_range(0, 400)) / 1000);
                return v[19:0];
            end
            default: return 20'($urandom() >> $urandom_range(0, 19));
        endcase
    endfunction

    // output side: after each result, drop ready for a randomly drawn wait, unless sink_on
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            sb.check_gain(gain_change_db, level_error);
            sink_draw = sink_on ? 0 : $urandom_range(0, 5);
            sink_wait <= sink_draw;
            out_ready <= (sink_draw == 0);
        end
        else if (sink_wait > 0)
        begin
            sink_wait <= sink_wait - 1;
            out_ready <= (sink_wait == 1);
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [19:0] targets[6];
        logic [19:0] tgt;
        sb = new();
        sink_on = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        measured_level = '0;
        cfg_valid = 1'b0;
        target_level = '0;
        idle_cycles(4);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset target, directed edges
        send_level(20'd0, 0);
        send_level(20'd1, 0);
        send_level(20'hFFFFF, 0);
        send_level(20'd1000, 0);
        send_level(20'd1159, 0);
        send_level(20'd1160, 0);
        send_level(20'd841, 0);
        send_level(20'd840, 0);
        send_level(20'd500, 0);
        send_level(20'd2000, 0);
        send_level(20'd3100, 1);
        send_level(20'd260, 1);

        write_target(20'd0);
        send_level(20'd1000, 0);
        send_level(20'd0, 0);
        write_target(20'hFFFFF);
        send_level(20'd1, 0);
        send_level(20'hFFFFF, 0);
        send_level(20'h80000, 0);
        write_target(20'd1);
        send_level(20'hFFFFF, 0);
        send_level(20'd1, 0);
        send_level(20'd2, 0);

        targets = '{20'd1000, 20'd1, 20'hFFFFF, 20'd37, 20'h5A5A5, 20'd0};
        for (int p = 0; p < 6; p++)
        begin
            tgt = (p == 3) ? 20'($urandom()) : targets[p];
            write_target(tgt);
            sink_on = (p == 2);
            for (int i = 0; i < 80; i++)
            begin
                send_level(rand_level(tgt), (p != 1) && (i % 20 < 14));
                if (i == 40) drain();
            end
        end
        sink_on = 1'b1;
        drain();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lgsc_pkg.sv
rtl/core/lock_gain_step_calculator_top.sv
tb/tb_lock_gain_step_calculator_top.sv
